@@ hdl/sha_pkg.sv @@
// shared types, round constants and sigma functions for the sha-256 hasher
`timescale 1ns / 1ps

package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_item_t;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

@@ hdl/sha256_message_hasher.sv @@
// sha-256 hasher top level: byte packer, padder, round sequencer and digest output
//
//  channel | valid     | stall     | payload                    | items
//  --------+-----------+-----------+----------------------------+-------------------------
//  message | msg_valid | msg_stall | msg_item  (msg_item_t)     | one byte and/or end mark
//  digest  | dig_valid | dig_stall | dig_item  (dig_item_t)     | eight words h0..h7
//
// a byte item that completes no block does not hold the input; the byte that completes
// a 64-byte block holds it through the rounds and the chain update, one round per
// cycle in the shared round unit. an end item pads one byte per cycle to the end of
// each padding block, compresses one or two blocks, then offers the eight words.
// reset loads the initial hash values and clears all counters; no clearing pass.
// msg_stall is high whenever the sequencer is busy or the digest is being read out;
// dig_stall only holds the current word in place.
`timescale 1ns / 1ps

module sha256_message_hasher
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    output logic      msg_stall,
    input  msg_item_t msg_item,
    output logic      dig_valid,
    input  logic      dig_stall,
    output dig_item_t dig_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        last_pend_reg, last_pend_next;
    logic        pad_reg, pad_next;
    logic        mark_reg, mark_next;
    logic        len_ok_reg, len_ok_next;
    logic        fin_reg, fin_next;
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];

    // datapath, no reset
    logic [511:0] block_reg;
    logic [31:0]  work_reg [8];
    logic [63:0]  len_reg;

    logic        msg_acc;
    logic        dig_acc;
    logic        shift_byte;
    logic [7:0]  byte_in;
    logic        load_work;
    logic        do_round;
    logic        load_len;
    logic        shift_len;
    logic [7:0]  pad_byte;
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    assign msg_acc   = msg_valid && !msg_stall;
    assign dig_acc   = dig_valid && !dig_stall;
    assign msg_stall = (state_reg != S_IDLE);
    assign dig_valid = (state_reg == S_OUT);

    assign dig_item.digest_word = chain_reg[0];
    assign dig_item.word_index  = idx_reg;
    assign dig_item.last_word   = (idx_reg == 3'd7);

    // window word j is block_reg[511-32*j -: 32], oldest first
    assign w_cur = block_reg[511:480];
    assign w_new = small_sigma1(block_reg[63:32]) + block_reg[223:192]
                 + small_sigma0(block_reg[479:448]) + w_cur;
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + choose(work_reg[4], work_reg[5], work_reg[6]) + ROUND_K[round_reg] + w_cur;
    assign t2 = big_sigma0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);

    // marker first, then zeros, length in the last eight bytes of the final block
    always_comb
    begin
        if (!mark_reg)
        begin
            pad_byte = PAD_MARKER;
        end
        else if (fill_reg[5:3] == 3'b111 && len_ok_reg)
        begin
            pad_byte = len_reg[63:56];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        last_pend_next = last_pend_reg;
        pad_next       = pad_reg;
        mark_next      = mark_reg;
        len_ok_next    = len_ok_reg;
        fin_next       = fin_reg;
        chain_next     = chain_reg;
        shift_byte     = 1'b0;
        byte_in        = msg_item.data_byte;
        load_work      = 1'b0;
        do_round       = 1'b0;
        load_len       = 1'b0;
        shift_len      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (msg_acc)
                begin
                    if (msg_item.has_byte)
                    begin
                        shift_byte = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                    end
                    if (msg_item.has_byte && fill_reg == 6'd63)
                    begin
                        load_work      = 1'b1;
                        last_pend_next = msg_item.last_byte;
                        state_next     = S_ROUND;
                    end
                    else if (msg_item.last_byte)
                    begin
                        pad_next   = 1'b1;
                        state_next = S_PAD;
                    end
                end
            end
            S_ROUND:
            begin
                do_round   = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (fin_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = S_OUT;
                end
                else if (pad_reg || last_pend_reg)
                begin
                    pad_next       = 1'b1;
                    last_pend_next = 1'b0;
                    // marker went into the block just folded, length follows in this one
                    if (mark_reg)
                    begin
                        len_ok_next = 1'b1;
                    end
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PAD:
            begin
                shift_byte = 1'b1;
                byte_in    = pad_byte;
                fill_next  = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next   = 1'b1;
                    len_ok_next = (fill_reg[5:3] != 3'b111);
                    load_len    = 1'b1;
                end
                else if (fill_reg[5:3] == 3'b111 && len_ok_reg)
                begin
                    shift_len = 1'b1;
                end
                if (fill_reg == 6'd63)
                begin
                    fin_next   = mark_reg && len_ok_reg;
                    load_work  = 1'b1;
                    state_next = S_ROUND;
                end
            end
            S_OUT:
            begin
                if (dig_acc)
                begin
                    idx_next = idx_reg + 3'd1;
                    for (int i = 0; i < 7; i++)
                    begin
                        chain_next[i] = chain_reg[i + 1];
                    end
                    chain_next[7] = chain_reg[0];
                    if (idx_reg == 3'd7)
                    begin
                        chain_next     = INIT_HASH;
                        count_next     = '0;
                        fill_next      = '0;
                        idx_next       = '0;
                        last_pend_next = 1'b0;
                        pad_next       = 1'b0;
                        mark_next      = 1'b0;
                        len_ok_next    = 1'b0;
                        fin_next       = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            last_pend_reg <= 1'b0;
            pad_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            len_ok_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            chain_reg     <= INIT_HASH;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            last_pend_reg <= last_pend_next;
            pad_reg       <= pad_next;
            mark_reg      <= mark_next;
            len_ok_reg    <= len_ok_next;
            fin_reg       <= fin_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_byte)
        begin
            block_reg <= {block_reg[503:0], byte_in};
        end
        else if (do_round)
        begin
            block_reg <= {block_reg[479:0], w_new};
        end

        if (load_work)
        begin
            work_reg <= chain_reg;
        end
        else if (do_round)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end

        if (load_len)
        begin
            len_reg <= {count_reg, 3'b000};
        end
        else if (shift_len)
        begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
    end

    // rounds always start on a whole block
    a_round_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (fill_reg == 6'd0))
        else $error("compression running on a partly filled block");

    a_round_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ROUND) |-> (round_reg == 6'd0))
        else $error("round counter left non-zero outside the rounds");

    a_end_starts_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_acc && msg_item.last_byte) |=> (state_reg == S_PAD || state_reg == S_ROUND))
        else $error("end item did not start padding");

    a_reinit_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_acc && dig_item.last_word) |=>
            (state_reg == S_IDLE && count_reg == 61'd0 && chain_reg[0] == INIT_HASH[0]
             && !pad_reg && !mark_reg))
        else $error("hasher not back to the initial state after the digest");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the sha-256 message hasher
`timescale 1ns / 1ps

module testbench;
    import sha_pkg::*;

    typedef struct packed {
        msg_item_t    item;
        logic         pinned;
        logic [255:0] digest;
    } stim_row_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned TARGET_ITEMS = 350;
    localparam int unsigned DRAIN_CYCLES = 400;

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // message lengths around the padding and block boundaries
    localparam int unsigned EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    localparam int N_DIRECTED = 18;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // empty message
        '{'{8'h00, 1'b0, 1'b1}, 1'b1,
          {128'he3b0c44298fc1c149afbf4c8996fb924, 128'h27ae41e4649b934ca495991b7852b855}},
        '{'{8'hff, 1'b0, 1'b0}, 1'b0, 256'h0},
        '{'{8'h5a, 1'b0, 1'b1}, 1'b0, 256'h0},
        // "abc" with an empty item in the middle
        '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, 256'h0},
        '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h63, 1'b1, 1'b1}, 1'b1,
          {128'hba7816bf8f01cfea414140de5dae2223, 128'hb00361a396177a9cb410ff61f20015ad}},
        '{'{8'hff, 1'b1, 1'b1}, 1'b0, 256'h0},
        '{'{8'h00, 1'b1, 1'b1}, 1'b0, 256'h0},
        '{'{8'h00, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'hff, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'hff, 1'b0, 1'b1}, 1'b0, 256'h0},
        '{'{8'haa, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h55, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h80, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h01, 1'b1, 1'b0}, 1'b0, 256'h0},
        '{'{8'h7f, 1'b0, 1'b0}, 1'b0, 256'h0},
        '{'{8'hfe, 1'b1, 1'b1}, 1'b0, 256'h0}
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      msg_valid = 1'b0;
    logic      msg_stall;
    msg_item_t msg_item = '0;
    logic      dig_valid;
    logic      dig_stall = 1'b0;
    dig_item_t dig_item;

    // predictor state
    logic [31:0] chain_h [8];
    logic [31:0] sched_w [16];
    logic [60:0] msg_len;

    dig_item_t   pending_words [$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned messages = 0;
    int unsigned words_checked = 0;
    int unsigned two_block_pads = 0;

    sha256_message_hasher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_item  (msg_item),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig_item  (dig_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic clear_state();
        for (int i = 0; i < 8; i++)
            chain_h[i] = H_START[i];
        for (int i = 0; i < 16; i++)
            sched_w[i] = '0;
        msg_len = '0;
    endtask

    task automatic put_byte(input logic [5:0] pos, input logic [7:0] b);
        sched_w[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = b;
    endtask

    task automatic compress_block();
        logic [31:0] v [8];
        logic [31:0] w, x, y, t1, t2;
        for (int i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                w = sched_w[r];
            else
            begin
                // schedule rolls through the sixteen stored words
                x = sched_w[(r - 15) % 16];
                y = sched_w[(r - 2) % 16];
                w = sched_w[r % 16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3))
                    + sched_w[(r - 7) % 16] + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
                sched_w[r % 16] = w;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROUND[r] + w;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
        for (int i = 0; i < 16; i++)
            sched_w[i] = '0;
    endtask

    task automatic absorb_item(input msg_item_t it, output bit done, output logic [255:0] digest);
        logic [5:0]  pos;
        logic [63:0] nbits;
        done = 1'b0;
        digest = '0;
        if (it.has_byte)
        begin
            pos = msg_len[5:0];
            put_byte(pos, it.data_byte);
            msg_len = msg_len + 61'd1;
            if (pos == 6'd63)
                compress_block();
        end
        if (it.last_byte)
        begin
            pos = msg_len[5:0];
            put_byte(pos, PAD_BYTE);
            // no room left for the length field: it goes in a second block
            if (pos >= 6'd56)
            begin
                compress_block();
                two_block_pads++;
            end
            nbits = {msg_len, 3'b000};
            sched_w[14] = nbits[63:32];
            sched_w[15] = nbits[31:0];
            compress_block();
            for (int i = 0; i < 8; i++)
                digest[255 - 32 * i -: 32] = chain_h[i];
            done = 1'b1;
            clear_state();
        end
    endtask

    task automatic feed(input msg_item_t it, input bit pinned = 1'b0,
                        input logic [255:0] pin = '0);
        bit           done;
        logic [255:0] digest;
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_valid <= 1'b0;
            @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg_item  <= it;
        do @(posedge clk); while (msg_stall);
        if (it.has_byte || it.last_byte)
            items_sent++;
        absorb_item(it, done, digest);
        if (done)
        begin
            if (pinned)
                digest = pin;
            messages++;
            for (int i = 0; i < 8; i++)
                pending_words.push_back('{digest_word: digest[255 - 32 * i -: 32],
                                          word_index: 3'(i), last_word: (i == 7)});
        end
    endtask

    task automatic send_message(input int unsigned n_bytes);
        bit        tail_byte;
        msg_item_t it;
        tail_byte = (n_bytes != 0) && ($urandom_range(1) == 1);
        for (int unsigned k = 0; k + tail_byte < n_bytes; k++)
        begin
            // now and then an empty item inside the message
            if ($urandom_range(9) == 0)
                feed('{data_byte: 8'($urandom_range(255)), has_byte: 1'b0, last_byte: 1'b0});
            feed('{data_byte: 8'($urandom_range(255)), has_byte: 1'b1, last_byte: 1'b0});
        end
        it = '{data_byte: 8'($urandom_range(255)), has_byte: tail_byte, last_byte: 1'b1};
        feed(it);
    endtask

    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return $urandom_range(12);
        if (sel < 85)
            return EDGE_LENS[$urandom_range(9)];
        return $urandom_range(130);
    endfunction

    always @(posedge clk)
        dig_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        dig_item_t want;
        if (rst_n && dig_valid && !dig_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("digest item with nothing expected: word %h index %0d",
                       dig_item.digest_word, dig_item.word_index);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (dig_item.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h, got %h", want.digest_word,
                           dig_item.digest_word);
                    mismatches++;
                end
                if (dig_item.word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d, got %0d", want.word_index,
                           dig_item.word_index);
                    mismatches++;
                end
                if (dig_item.last_word !== want.last_word)
                begin
                    $error("last_word: expected %0b, got %0b", want.last_word,
                           dig_item.last_word);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        clear_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < N_DIRECTED; n++)
            feed(DIRECTED[n].item, DIRECTED[n].pinned, DIRECTED[n].digest);

        // no idling, sender gaps, receiver stalls, then both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 52 : (ph == 3) ? 26 : 0;
            recv_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 26 : 0;
            while (items_sent < N_DIRECTED + (ph + 1) * TARGET_ITEMS / 4)
                send_message(pick_length());
        end
        msg_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d message items in %0d messages, %0d digest words checked",
                 items_sent, messages, words_checked);
        $display("%0d messages needed a second padding block", two_block_pads);
        if (mismatches == 0)
            $display("[sha256_message_hasher] OK");
        else
            $display("[sha256_message_hasher] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[sha256_message_hasher] ERROR");
        $finish;
    end

endmodule
